### hw/rtl/minv_pkg.sv
// ----------------------------------------------------------------------------
// minv_pkg
// Shared types, widths and index tables for the 4x4 matrix inverse block.
// ----------------------------------------------------------------------------
`default_nettype none

package minv_pkg;

	localparam int ELEM_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int LIMB_W    = 32;
	localparam int COF_MAG_W = 2 * ELEM_W;           // |a*b - c*d| <= 2^63
	localparam int ADJ_MAG_W = 3 * LIMB_W;           // three terms, each <= 2^94
	localparam int DET_MAG_W = ADJ_MAG_W + ELEM_W + 2; // four terms of 127 bits
	localparam int ACC_W     = DET_MAG_W + 2;
	localparam int NUM_W     = ADJ_MAG_W + 2 * FRAC_BITS;
	localparam int QUO_W     = ELEM_W + 1;
	localparam int REM_W     = DET_MAG_W + 1;
	localparam int NUM_COF   = 18;

	typedef struct packed {
		logic signed [ELEM_W-1:0] elem_value;
		logic        [3:0]        elem_pos;
	} elem_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] inv_value;
		logic        [3:0]        inv_pos;
		logic                     last_elem;
		logic                     is_singular;
		logic                     did_saturate;
	} inv_t;

	typedef struct packed {
		logic       clr;
		logic       mul_en;
		logic       acc_en;
		logic       neg;
		logic [1:0] shift;
	} mac_ctrl_t;

	typedef struct packed {
		logic              done;
		logic              sat;
		logic [ELEM_W-1:0] value;
	} div_res_t;

	// 2x2 cofactor element pairs, entry = 3*group + sel: {a, b, c, d} -> a*b - c*d
	localparam logic [3:0] COF_IDX [NUM_COF][4] = '{
		'{4'd10, 4'd15, 4'd14, 4'd11}, '{4'd6, 4'd15, 4'd14, 4'd7}, '{4'd6, 4'd11, 4'd10, 4'd7},
		'{4'd9,  4'd15, 4'd13, 4'd11}, '{4'd5, 4'd15, 4'd13, 4'd7}, '{4'd5, 4'd11, 4'd9,  4'd7},
		'{4'd9,  4'd14, 4'd13, 4'd10}, '{4'd5, 4'd14, 4'd13, 4'd6}, '{4'd5, 4'd10, 4'd9,  4'd6},
		'{4'd8,  4'd15, 4'd12, 4'd11}, '{4'd4, 4'd15, 4'd12, 4'd7}, '{4'd4, 4'd11, 4'd8,  4'd7},
		'{4'd8,  4'd14, 4'd12, 4'd10}, '{4'd4, 4'd14, 4'd12, 4'd6}, '{4'd4, 4'd10, 4'd8,  4'd6},
		'{4'd8,  4'd13, 4'd12, 4'd9},  '{4'd4, 4'd13, 4'd12, 4'd5}, '{4'd4, 4'd9,  4'd8,  4'd5}
	};

	// per adjugate column: three (row, cofactor group) pairs, signs + - +, flipped when column + row is odd
	localparam logic [2:0] COL_TERMS [4][6] = '{
		'{3'd1, 3'd0, 3'd2, 3'd1, 3'd3, 3'd2},
		'{3'd0, 3'd0, 3'd2, 3'd3, 3'd3, 3'd4},
		'{3'd0, 3'd1, 3'd1, 3'd3, 3'd3, 3'd5},
		'{3'd0, 3'd2, 3'd1, 3'd4, 3'd2, 3'd5}
	};

endpackage

`default_nettype wire

### hw/rtl/minv_mac.sv
// ----------------------------------------------------------------------------
// minv_mac
// Shared 32x32 multiplier with a wide signed accumulator, one limb per pass.
// ----------------------------------------------------------------------------
`default_nettype none

module minv_mac (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire minv_pkg::mac_ctrl_t             ctrl,
	input  wire logic [minv_pkg::LIMB_W-1:0]     a,
	input  wire logic [minv_pkg::LIMB_W-1:0]     b,
	output logic signed [minv_pkg::ACC_W-1:0]    acc
);

	logic [2*minv_pkg::LIMB_W-1:0] prod_q;
	logic                          prod_neg_q;
	logic [1:0]                    prod_sh_q;
	logic signed [minv_pkg::ACC_W-1:0] acc_q;
	logic [minv_pkg::ACC_W-1:0]    term;

	assign term = minv_pkg::ACC_W'(prod_q) << (minv_pkg::LIMB_W * prod_sh_q);
	assign acc  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q     <= '0;
			prod_neg_q <= 1'b0;
			prod_sh_q  <= '0;
			acc_q      <= '0;
		end else begin
			if (ctrl.mul_en) begin
				prod_q     <= (2*minv_pkg::LIMB_W)'(a) * (2*minv_pkg::LIMB_W)'(b);
				prod_neg_q <= ctrl.neg;
				prod_sh_q  <= ctrl.shift;
			end
			if (ctrl.clr) begin
				acc_q <= '0;
			end else if (ctrl.acc_en) begin
				acc_q <= prod_neg_q ? acc_q - $signed(term) : acc_q + $signed(term);
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/minv_div.sv
// ----------------------------------------------------------------------------
// minv_div
// Restoring divider: |adj| * 2^(2*FRAC) / |det|, one quotient bit a cycle,
// with saturation to the signed element range.
// ----------------------------------------------------------------------------
`default_nettype none

module minv_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [minv_pkg::ADJ_MAG_W-1:0]     num_mag,
	input  wire logic                               num_neg,
	input  wire logic [minv_pkg::DET_MAG_W-1:0]     den_mag,
	input  wire logic                               den_neg,
	output minv_pkg::div_res_t                      res
);

	typedef enum logic [1:0] {D_IDLE, D_CHECK, D_ITER, D_FIN} dstate_t;

	dstate_t                          state_q;
	logic [minv_pkg::REM_W-1:0]       rem_q;
	logic [minv_pkg::QUO_W-1:0]       nsh_q;
	logic [minv_pkg::QUO_W-1:0]       quo_q;
	logic [minv_pkg::DET_MAG_W-1:0]   den_q;
	logic                             neg_q;
	logic                             big_q;
	logic [5:0]                       cnt_q;
	minv_pkg::div_res_t               res_q;

	logic [minv_pkg::NUM_W-1:0]       nfull;
	logic [minv_pkg::REM_W-1:0]       trial;
	logic                             ge;
	logic [minv_pkg::QUO_W-1:0]       limit;
	logic                             sat;
	logic [minv_pkg::QUO_W-1:0]       mag;

	assign nfull = {num_mag, {(2*minv_pkg::FRAC_BITS){1'b0}}};
	assign trial = {rem_q[minv_pkg::REM_W-2:0], nsh_q[minv_pkg::QUO_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign limit = (minv_pkg::QUO_W'(1) << (minv_pkg::ELEM_W - 1)) - minv_pkg::QUO_W'(!neg_q);
	assign sat   = big_q || (quo_q > limit);
	assign mag   = sat ? limit : quo_q;
	assign res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			rem_q   <= '0;
			nsh_q   <= '0;
			quo_q   <= '0;
			den_q   <= '0;
			neg_q   <= 1'b0;
			big_q   <= 1'b0;
			cnt_q   <= '0;
			res_q   <= '0;
		end else begin
			res_q.done <= (state_q == D_FIN);
			case (state_q)
				D_IDLE: begin
					if (start) begin
						// quotient fits QUO_W bits unless the top part already reaches den
						rem_q   <= minv_pkg::REM_W'(nfull >> minv_pkg::QUO_W);
						nsh_q   <= nfull[minv_pkg::QUO_W-1:0];
						den_q   <= den_mag;
						neg_q   <= num_neg ^ den_neg;
						quo_q   <= '0;
						big_q   <= 1'b0;
						cnt_q   <= '0;
						state_q <= D_CHECK;
					end
				end
				D_CHECK: begin
					if (rem_q >= {1'b0, den_q}) begin
						big_q   <= 1'b1;
						state_q <= D_FIN;
					end else begin
						state_q <= D_ITER;
					end
				end
				D_ITER: begin
					rem_q <= ge ? trial - {1'b0, den_q} : trial;
					quo_q <= {quo_q[minv_pkg::QUO_W-2:0], ge};
					nsh_q <= nsh_q << 1;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(minv_pkg::QUO_W - 1)) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					res_q.sat   <= sat;
					res_q.value <= neg_q ? minv_pkg::ELEM_W'(-mag) : minv_pkg::ELEM_W'(mag);
					state_q     <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/matrix4x4_inverse_top.sv
// ----------------------------------------------------------------------------
// matrix4x4_inverse_top
// 4x4 fixed-point matrix inverse by the adjugate, on one shared MAC and
// one shared restoring divider.
// ----------------------------------------------------------------------------
// Element loads below position 15 only write the matrix store.
// The position-15 request computes cofactors, adjugate and determinant on the
// single 32x32 multiplier, then each result in the bit-serial divider.
// A singular matrix gives its 16 results after the determinant without the divider,
// each straight after the one before while inv_ready stays high.
// Reset clears the control and result registers; the matrix store holds garbage until written.
`default_nettype none

module matrix4x4_inverse_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             elem_valid,
	output logic                  elem_ready,
	input  wire minv_pkg::elem_t  elem,
	output logic                  inv_valid,
	input  wire logic             inv_ready,
	output minv_pkg::inv_t        inv
);

	typedef enum logic [2:0] {
		S_IDLE, S_LOADA, S_MUL, S_ACC, S_STORE, S_DIVGO, S_DIVW, S_OUT
	} state_t;
	typedef enum logic [1:0] {P_COF, P_ADJ, P_DET} phase_t;

	state_t  state_q;
	phase_t  phase_q;
	logic [4:0] ent_q;
	logic [1:0] term_q;
	logic [1:0] limb_q;
	logic [3:0] oidx_q;
	logic [minv_pkg::LIMB_W-1:0] a_mag_q;
	logic                        a_neg_q;
	logic [minv_pkg::DET_MAG_W-1:0] det_mag_q;
	logic                           det_neg_q;
	logic                           det_zero_q;
	minv_pkg::inv_t inv_q;
	logic           inv_valid_q;

	logic [minv_pkg::ELEM_W-1:0]    m_mag_q   [16];
	logic                           m_neg_q   [16];
	logic [minv_pkg::COF_MAG_W-1:0] cof_mag_q [minv_pkg::NUM_COF];
	logic                           cof_neg_q [minv_pkg::NUM_COF];
	logic [minv_pkg::ADJ_MAG_W-1:0] adj_mag_q [16];
	logic                           adj_neg_q [16];

	logic        accept;
	logic [3:0]  ia, ib, m_idx;
	logic [4:0]  ci;
	logic [3:0]  ai;
	logic        tsign;
	logic [1:0]  c_col, k_row;
	logic [2:0]  row, grp;
	logic [1:0]  sel;
	logic        term_last, limb_last;
	logic [minv_pkg::ADJ_MAG_W-1:0] b_mag;
	logic        b_neg;
	logic [minv_pkg::LIMB_W-1:0] b_limb;
	logic [minv_pkg::ELEM_W-1:0] in_mag;
	minv_pkg::mac_ctrl_t mac_ctrl;
	logic signed [minv_pkg::ACC_W-1:0] acc;
	logic [minv_pkg::ACC_W-1:0] acc_abs;
	logic        div_start;
	minv_pkg::div_res_t div_res;

	assign accept     = elem_valid && elem_ready;
	assign elem_ready = (state_q == S_IDLE);
	assign inv_valid  = inv_valid_q;
	assign inv        = inv_q;
	assign in_mag     = elem.elem_value[minv_pkg::ELEM_W-1] ?
		minv_pkg::ELEM_W'(-elem.elem_value) : elem.elem_value;
	assign acc_abs    = acc[minv_pkg::ACC_W-1] ? minv_pkg::ACC_W'(-acc) : acc;

	// operand indexes for the current product term
	assign c_col = ent_q[3:2];
	assign k_row = ent_q[1:0];
	assign row   = minv_pkg::COL_TERMS[c_col][{term_q, 1'b0}];
	assign grp   = minv_pkg::COL_TERMS[c_col][{term_q, 1'b1}];
	assign sel   = (k_row == 2'd0) ? 2'd0 : k_row - 2'd1;

	always_comb begin
		ia    = '0;
		ib    = '0;
		ci    = 5'(grp) * 5'd3 + 5'(sel);
		ai    = (phase_q == P_DET) ? {term_q, 2'b00} : oidx_q;
		tsign = 1'b0;
		term_last = 1'b0;
		limb_last = 1'b0;
		case (phase_q)
			P_COF: begin
				ia        = minv_pkg::COF_IDX[ent_q][{term_q[0], 1'b0}];
				ib        = minv_pkg::COF_IDX[ent_q][{term_q[0], 1'b1}];
				tsign     = term_q[0];
				term_last = (term_q == 2'd1);
				limb_last = (limb_q == 2'd0);
			end
			P_ADJ: begin
				ia        = (k_row == 2'd0) ? 4'(row) + 4'd4 : 4'(row);
				tsign     = (term_q == 2'd1) ^ c_col[0] ^ k_row[0];
				term_last = (term_q == 2'd2);
				limb_last = (limb_q == 2'd1);
			end
			P_DET: begin
				ia        = {2'b00, term_q};
				term_last = (term_q == 2'd3);
				limb_last = (limb_q == 2'd2);
			end
			default: begin
				ia = '0;
			end
		endcase
	end

	assign m_idx = (state_q == S_MUL) ? ib : ia;

	always_comb begin
		case (phase_q)
			P_COF: begin
				b_mag = minv_pkg::ADJ_MAG_W'(m_mag_q[m_idx]);
				b_neg = m_neg_q[m_idx];
			end
			P_ADJ: begin
				b_mag = minv_pkg::ADJ_MAG_W'(cof_mag_q[ci]);
				b_neg = cof_neg_q[ci];
			end
			default: begin
				b_mag = adj_mag_q[ai];
				b_neg = adj_neg_q[ai];
			end
		endcase
		case (limb_q)
			2'd0:    b_limb = b_mag[minv_pkg::LIMB_W-1:0];
			2'd1:    b_limb = b_mag[2*minv_pkg::LIMB_W-1:minv_pkg::LIMB_W];
			default: b_limb = b_mag[3*minv_pkg::LIMB_W-1:2*minv_pkg::LIMB_W];
		endcase
	end

	assign mac_ctrl.clr    = (accept && elem.elem_pos == 4'd15) || (state_q == S_STORE);
	assign mac_ctrl.mul_en = (state_q == S_MUL);
	assign mac_ctrl.acc_en = (state_q == S_ACC);
	assign mac_ctrl.neg    = tsign ^ a_neg_q ^ b_neg;
	assign mac_ctrl.shift  = limb_q;
	assign div_start       = (state_q == S_DIVGO);

	minv_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (a_mag_q),
		.b      (b_limb),
		.acc    (acc)
	);

	minv_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (adj_mag_q[ai]),
		.num_neg (adj_neg_q[ai]),
		.den_mag (det_mag_q),
		.den_neg (det_neg_q),
		.res     (div_res)
	);

	// stores: sign and magnitude, one entry a cycle on an accepted element or in S_STORE
	always_ff @(posedge clk) begin
		if (accept) begin
			m_mag_q[elem.elem_pos] <= in_mag;
			m_neg_q[elem.elem_pos] <= elem.elem_value[minv_pkg::ELEM_W-1];
		end
		if (state_q == S_STORE && phase_q == P_COF) begin
			cof_mag_q[ent_q] <= acc_abs[minv_pkg::COF_MAG_W-1:0];
			cof_neg_q[ent_q] <= acc[minv_pkg::ACC_W-1];
		end
		if (state_q == S_STORE && phase_q == P_ADJ) begin
			adj_mag_q[ent_q[3:0]] <= acc_abs[minv_pkg::ADJ_MAG_W-1:0];
			adj_neg_q[ent_q[3:0]] <= acc[minv_pkg::ACC_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= P_COF;
			ent_q       <= '0;
			term_q      <= '0;
			limb_q      <= '0;
			oidx_q      <= '0;
			a_mag_q     <= '0;
			a_neg_q     <= 1'b0;
			det_mag_q   <= '0;
			det_neg_q   <= 1'b0;
			det_zero_q  <= 1'b0;
			inv_q       <= '0;
			inv_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && elem.elem_pos == 4'd15) begin
						phase_q <= P_COF;
						ent_q   <= '0;
						term_q  <= '0;
						limb_q  <= '0;
						state_q <= S_LOADA;
					end
				end
				S_LOADA: begin
					a_mag_q <= m_mag_q[m_idx];
					a_neg_q <= m_neg_q[m_idx];
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (!limb_last) begin
						limb_q  <= limb_q + 2'd1;
						state_q <= S_MUL;
					end else begin
						limb_q <= '0;
						if (!term_last) begin
							term_q  <= term_q + 2'd1;
							state_q <= S_LOADA;
						end else begin
							term_q  <= '0;
							state_q <= S_STORE;
						end
					end
				end
				S_STORE: begin
					case (phase_q)
						P_COF: begin
							if (ent_q == 5'(minv_pkg::NUM_COF - 1)) begin
								ent_q   <= '0;
								phase_q <= P_ADJ;
							end else begin
								ent_q <= ent_q + 5'd1;
							end
							state_q <= S_LOADA;
						end
						P_ADJ: begin
							if (ent_q == 5'd15) begin
								ent_q   <= '0;
								phase_q <= P_DET;
							end else begin
								ent_q <= ent_q + 5'd1;
							end
							state_q <= S_LOADA;
						end
						default: begin
							det_mag_q  <= acc_abs[minv_pkg::DET_MAG_W-1:0];
							det_neg_q  <= acc[minv_pkg::ACC_W-1];
							det_zero_q <= (acc == '0);
							phase_q    <= P_COF;
							oidx_q     <= '0;
							if (acc == '0) begin
								inv_q       <= '{inv_value: '0, inv_pos: 4'd0, last_elem: 1'b0,
									is_singular: 1'b1, did_saturate: 1'b0};
								inv_valid_q <= 1'b1;
								state_q     <= S_OUT;
							end else begin
								state_q <= S_DIVGO;
							end
						end
					endcase
				end
				S_DIVGO: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_res.done) begin
						inv_q.inv_value    <= div_res.value;
						inv_q.inv_pos      <= oidx_q;
						inv_q.last_elem    <= (oidx_q == 4'd15);
						inv_q.is_singular  <= 1'b0;
						inv_q.did_saturate <= div_res.sat;
						inv_valid_q        <= 1'b1;
						state_q            <= S_OUT;
					end
				end
				S_OUT: begin
					if (inv_ready) begin
						if (oidx_q == 4'd15) begin
							inv_valid_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							oidx_q <= oidx_q + 4'd1;
							if (det_zero_q) begin
								// singular: hold valid, next zero result straight away
								inv_q.inv_pos   <= oidx_q + 4'd1;
								inv_q.last_elem <= (oidx_q == 4'd14);
							end else begin
								inv_valid_q <= 1'b0;
								state_q     <= S_DIVGO;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_div_only_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == S_DIVW)
		else $error("divider result outside wait state");

	a_no_load_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(elem_ready && inv_valid))
		else $error("request taken while a result is pending");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv_ready && inv.last_elem |=> elem_ready)
		else $error("block not idle after the last result");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv.is_singular |-> inv.inv_value == '0 && !inv.did_saturate)
		else $error("singular result with nonzero value");

endmodule

`default_nettype wire
